>>> rtl/fkb_pkg.sv
// ----------------------------------------------------------------------------
// fkb_pkg: shared types for the fractional knapsack bound
// Stop codes, the entry type that crosses the front-to-back queue, the
// result type and the back-end state encoding.
// ----------------------------------------------------------------------------
package fkb_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned PROFIT_W   = 48;
  localparam int unsigned IDX_OUT_W  = 17;
  localparam int unsigned SHARE_W    = 31;

  localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

  typedef enum logic [1:0] {
    STOP_CAPACITY  = 2'd0,
    STOP_NONPOS    = 2'd1,
    STOP_FRACTION  = 2'd2,
    STOP_EXHAUSTED = 2'd3
  } stop_reason_t;

  // One finished run as classified by the front end. The last three fields
  // only matter for a fractional stop.
  typedef struct packed {
    logic [PROFIT_W-1:0]  profit;
    logic [WORD_W-1:0]    weight;
    logic [IDX_OUT_W-1:0] index;
    stop_reason_t         reason;
    logic [WORD_W-1:0]    residual;
    logic [SHARE_W-1:0]   item_p;
    logic [WORD_W-1:0]    item_w;
  } fkb_entry_t;

  typedef struct packed {
    logic [PROFIT_W-1:0]  total_profit;
    logic [WORD_W-1:0]    total_weight;
    logic [PROFIT_W-1:0]  upper_bound;
    logic [IDX_OUT_W-1:0] stop_index;
    stop_reason_t         stop_reason;
  } fkb_result_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_ADD  = 4'b1000
  } back_state_t;

endpackage

>>> rtl/fkb_front.sv
// ----------------------------------------------------------------------------
// fkb_front: run accumulator and stop classifier
// Accepts begin and item requests, keeps the running profit, weight and
// index, and pushes one entry into the queue when a run stops.
// ----------------------------------------------------------------------------
module fkb_front
  import fkb_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [WORD_W-1:0]   capacity,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [WORD_W-1:0]   fixed_profit,
  input  logic [WORD_W-1:0]   fixed_weight,
  input  logic [15:0]         start_index,
  input  logic                no_items,
  input  logic [WORD_W-1:0]   item_profit,
  input  logic [WORD_W-1:0]   item_weight,
  input  logic                is_last,
  input  logic                q_full,
  output logic                q_push,
  output fkb_entry_t          q_entry
);

  localparam int unsigned IDX_NEED = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IDX_W    = (IDX_NEED > IDX_OUT_W) ? IDX_NEED : IDX_OUT_W;
  localparam logic [IDX_W:0] MAX_IDX = (IDX_W + 1)'(MAX_ITEMS);

  logic [PROFIT_W-1:0] acc_profit, acc_profit_next;
  logic [WORD_W-1:0]   acc_weight, acc_weight_next;
  logic [IDX_W-1:0]    cur_index, cur_index_next;
  logic                run_done, run_done_next;

  logic                accept;
  logic [WORD_W:0]     new_w;
  logic [PROFIT_W:0]   psum;
  logic [PROFIT_W-1:0] profit_sat;
  logic [IDX_W:0]      idx_inc;
  logic [IDX_W:0]      start_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign new_w      = {1'b0, acc_weight} + {1'b0, item_weight};
  assign psum       = {1'b0, acc_profit} + (PROFIT_W + 1)'(item_profit[SHARE_W-1:0]);
  assign profit_sat = psum[PROFIT_W] ? PROFIT_MAX : psum[PROFIT_W-1:0];
  assign idx_inc    = {1'b0, cur_index} + (IDX_W + 1)'(1);
  assign start_ext  = (IDX_W + 1)'(start_index);

  always_comb begin
    acc_profit_next  = acc_profit;
    acc_weight_next  = acc_weight;
    cur_index_next   = cur_index;
    run_done_next    = run_done;
    q_push           = 1'b0;
    q_entry.profit   = acc_profit;
    q_entry.weight   = acc_weight;
    q_entry.index    = cur_index[IDX_OUT_W-1:0];
    q_entry.reason   = STOP_CAPACITY;
    q_entry.residual = capacity - acc_weight;
    q_entry.item_p   = item_profit[SHARE_W-1:0];
    q_entry.item_w   = item_weight;
    if (accept) begin
      if (!req_type) begin
        acc_profit_next = PROFIT_W'(fixed_profit);
        acc_weight_next = fixed_weight;
        cur_index_next  = IDX_W'(start_index);
        run_done_next   = 1'b0;
        if (no_items || (start_ext >= MAX_IDX)) begin
          q_push         = 1'b1;
          run_done_next  = 1'b1;
          q_entry.profit = PROFIT_W'(fixed_profit);
          q_entry.weight = fixed_weight;
          q_entry.index  = IDX_OUT_W'(start_index);
          q_entry.reason = STOP_EXHAUSTED;
        end
      end else if (!run_done) begin
        priority if (acc_weight >= capacity) begin
          q_push         = 1'b1;
          run_done_next  = 1'b1;
          q_entry.reason = STOP_CAPACITY;
        end else if (item_profit[WORD_W-1] || (item_profit == '0)) begin
          q_push         = 1'b1;
          run_done_next  = 1'b1;
          q_entry.reason = STOP_NONPOS;
        end else if (new_w <= {1'b0, capacity}) begin
          acc_profit_next = profit_sat;
          acc_weight_next = new_w[WORD_W-1:0];
          cur_index_next  = idx_inc[IDX_W-1:0];
          if (is_last || (idx_inc >= MAX_IDX)) begin
            q_push         = 1'b1;
            run_done_next  = 1'b1;
            q_entry.profit = profit_sat;
            q_entry.weight = new_w[WORD_W-1:0];
            q_entry.index  = idx_inc[IDX_OUT_W-1:0];
            q_entry.reason = STOP_EXHAUSTED;
          end
        end else begin
          q_push         = 1'b1;
          run_done_next  = 1'b1;
          q_entry.reason = STOP_FRACTION;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_profit <= '0;
      acc_weight <= '0;
      cur_index  <= '0;
      run_done   <= 1'b1;
    end else begin
      acc_profit <= acc_profit_next;
      acc_weight <= acc_weight_next;
      cur_index  <= cur_index_next;
      run_done   <= run_done_next;
    end
  end

endmodule

>>> rtl/fkb_queue.sv
// ----------------------------------------------------------------------------
// fkb_queue: two-entry queue between front and back
// Decouples the classifier from the bound unit so that each can stall alone.
// ----------------------------------------------------------------------------
module fkb_queue
  import fkb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  fkb_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output fkb_entry_t head
);

  fkb_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != 2'd3) |=> (count != 2'd3))
    else $error("queue count out of range");

endmodule

>>> rtl/fkb_back.sv
// ----------------------------------------------------------------------------
// fkb_back: bound unit and result register
// Passes whole-item stops straight to the output register; for a fractional
// stop it forms residual*p, divides by the item weight one bit per cycle and
// adds the floored share with saturation.
// ----------------------------------------------------------------------------
module fkb_back
  import fkb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  fkb_entry_t  q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output fkb_result_t out_result
);

  localparam logic [4:0] LAST_STEP = 5'(SHARE_W - 1);

  back_state_t         st;
  fkb_entry_t          work;
  logic [WORD_W-1:0]   rem;
  logic [SHARE_W-1:0]  low;
  logic [SHARE_W-1:0]  quo;
  logic [4:0]          cnt;

  logic                out_free;
  logic                out_load;
  logic [2*WORD_W-2:0] product;
  logic [WORD_W:0]     trial;
  logic                take;
  logic [PROFIT_W:0]   bsum;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (st == S_IDLE) && q_valid && out_free;
  // A result enters the output register either straight from the queue or
  // at the end of the fractional path.
  assign out_load = (q_pop && (q_head.reason != STOP_FRACTION)) ||
                    ((st == S_ADD) && out_free);
  assign product  = (2*WORD_W - 1)'(work.residual * work.item_p);
  assign trial    = {rem, low[SHARE_W-1]};
  assign take     = (trial >= {1'b0, work.item_w});
  assign bsum     = {1'b0, work.profit} + (PROFIT_W + 1)'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (q_pop && (q_head.reason == STOP_FRACTION)) begin
            st <= S_MUL;
          end
        end
        S_MUL: begin
          cnt <= '0;
          st  <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == LAST_STEP) begin
            st <= S_ADD;
          end
        end
        S_ADD: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        if (q_pop) begin
          work <= q_head;
          if (q_head.reason != STOP_FRACTION) begin
            out_result.total_profit <= q_head.profit;
            out_result.total_weight <= q_head.weight;
            out_result.upper_bound  <= q_head.profit;
            out_result.stop_index   <= q_head.index;
            out_result.stop_reason  <= q_head.reason;
          end
        end
      end
      S_MUL: begin
        // The share is below p, so the top bits of the product are below w.
        rem <= product[2*WORD_W-2:SHARE_W];
        low <= product[SHARE_W-1:0];
      end
      S_DIV: begin
        rem <= take ? WORD_W'(trial - {1'b0, work.item_w}) : trial[WORD_W-1:0];
        low <= {low[SHARE_W-2:0], 1'b0};
        quo <= {quo[SHARE_W-2:0], take};
      end
      S_ADD: begin
        if (out_free) begin
          out_result.total_profit <= work.profit;
          out_result.total_weight <= work.weight;
          out_result.upper_bound  <= bsum[PROFIT_W] ? PROFIT_MAX : bsum[PROFIT_W-1:0];
          out_result.stop_index   <= work.index;
          out_result.stop_reason  <= work.reason;
        end
      end
      default: ;
    endcase
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (st == S_DIV) |-> (rem < work.item_w))
    else $error("division remainder not below divisor");
  a_bound_not_below: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.upper_bound >= out_result.total_profit))
    else $error("bound below total profit");
  a_whole_stop_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_result.stop_reason != STOP_FRACTION))
      |-> (out_result.upper_bound == out_result.total_profit))
    else $error("bound differs from profit on a whole-item stop");
  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (st == S_DIV) |-> (cnt <= LAST_STEP))
    else $error("division ran past its last step");

endmodule

>>> rtl/fractional_knapsack_bound.sv
// ----------------------------------------------------------------------------
// fractional_knapsack_bound: greedy fractional knapsack upper bound
// Accumulates items sorted by profit/weight ratio against a capacity and
// reports the run totals and the bound with the floored fractional share.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                    Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata, tuser, tlast
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata
//   cfg       in         cfg_valid/cfg_ready          cfg_data (capacity)
//
// The front end takes one request per cycle whenever the two-entry queue has
// room; a request that stops a run takes a queue slot.
// A whole-item stop is loaded into the output register at the edge that pops
// it from the queue. A fractional stop passes through a multiply, then a
// bit-serial division and then an add in the back end.
// Reset is synchronous; it clears the capacity to zero and leaves no run open.
// A stalled output holds the back end, and once the queue fills the input
// stalls too. The capacity port is always ready.
module fractional_knapsack_bound
  import fkb_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 65536
) (
  input  logic         clk,
  input  logic         rst,
  // Stream input.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // From bit 0: fixed_profit[31:0], fixed_weight[31:0], start_index[15:0],
  // no_items, item_profit[31:0], item_weight[31:0], seven zero bits.
  input  logic [151:0] s_axis_tdata,
  // req_type: 0 begins a run, 1 carries one item.
  input  logic         s_axis_tuser,
  // is_last of an item request.
  input  logic         s_axis_tlast,
  // Stream output.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // From bit 0: total_profit[47:0], total_weight[31:0], upper_bound[47:0],
  // stop_index[16:0], stop_reason[1:0], five zero bits.
  output logic [151:0] m_axis_tdata,
  // Capacity write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  logic [WORD_W-1:0] capacity;
  logic              q_push, q_full, q_pop, q_valid;
  fkb_entry_t        q_entry, q_head;
  fkb_result_t       result;

  // The user must change configuration only while idle; not enforced here.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  fkb_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .capacity     (capacity),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .req_type     (s_axis_tuser),
    .fixed_profit (s_axis_tdata[31:0]),
    .fixed_weight (s_axis_tdata[63:32]),
    .start_index  (s_axis_tdata[79:64]),
    .no_items     (s_axis_tdata[80]),
    .item_profit  (s_axis_tdata[112:81]),
    .item_weight  (s_axis_tdata[144:113]),
    .is_last      (s_axis_tlast),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  fkb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  fkb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  // Output packing, lowest field first, zero fill to whole bytes.
  assign m_axis_tdata = {5'b0,
                         result.stop_reason,
                         result.stop_index,
                         result.upper_bound,
                         result.total_weight,
                         result.total_profit};

endmodule
